FILE: hdl/lzt_pkg.sv
// ----------------------------------------------------------------------------
// lzt_pkg: shared types and constants of the layer z-order table
// Operation codes, result kinds, state encoding and controller commands.
// ----------------------------------------------------------------------------
package lzt_pkg;

    localparam int MAX_LAYERS = 256;
    localparam int SW = $clog2(MAX_LAYERS);   // slot index width
    localparam int LW = SW + 1;               // signed level width

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_SETSIZE = 3'd1,
        OP_HEIGHT  = 3'd2,
        OP_SLIDE   = 3'd3,
        OP_REFRESH = 3'd4,
        OP_FREE    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        K_DONE  = 2'd0,
        K_RECT  = 2'd1,
        K_ALLOC = 2'd2,
        K_FULL  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,      // slot record read issued
        S_DECIDE,    // record available, choose action
        S_SEARCH,    // allocation scan, one slot per cycle
        S_SHIFT_RD,  // read one order entry
        S_SHIFT_WR,  // move entry and renumber its slot
        S_PLACE,     // put the slot at its new level
        S_EMIT1,
        S_EMIT2
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture input word
        logic rd_slot;     // read slot record
        logic scan_start;
        logic scan_step;
        logic calc_level;  // clamp height, set up shift
        logic hide;        // force target level -1 (free)
        logic shift_rd;
        logic shift_wr;
        logic place;
        logic store;       // write size/key/origin/used for the op
        logic emit1;
        logic emit2;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_op  op;
        logic valid_slot;   // addressed slot in use
        logic shown;        // old level >= 0
        logic scan_hit;
        logic scan_end;
        logic changed;      // level differs
        logic shift_more;   // more entries to move
        logic to_hidden;    // shift ends in hiding (no place)
    } t_stat;

endpackage

FILE: hdl/lzt_ctrl.sv
// ----------------------------------------------------------------------------
// lzt_ctrl: operation sequencer
// Steps each operation through read, search or shift, and result words.
// ----------------------------------------------------------------------------
module lzt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lzt_pkg::t_stat i_stat,
    output lzt_pkg::t_cmd  o_cmd
);
    import lzt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_READ;
            S_READ:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.op == OP_ALLOC) begin
                    n_state = S_SEARCH;
                end else if (!i_stat.valid_slot) begin
                    n_state = S_EMIT1;
                end else if ((i_stat.op == OP_HEIGHT)
                             || (i_stat.op == OP_FREE && i_stat.shown)) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_EMIT1;
                end
            end
            S_SEARCH: if (i_stat.scan_hit || i_stat.scan_end) n_state = S_EMIT1;
            S_SHIFT_RD: begin
                if (i_stat.shift_more) n_state = S_SHIFT_WR;
                else if (i_stat.changed && !i_stat.to_hidden) n_state = S_PLACE;
                else n_state = S_EMIT1;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_PLACE:    n_state = S_EMIT1;
            S_EMIT1: begin
                if (i_stat.op == OP_SLIDE && i_stat.valid_slot && i_stat.shown)
                    n_state = S_EMIT2;
                else
                    n_state = S_IDLE;
            end
            S_EMIT2: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.load = start;
            S_READ:   o_cmd.rd_slot = 1'b1;
            S_DECIDE: begin
                o_cmd.scan_start = (i_stat.op == OP_ALLOC);
                o_cmd.calc_level = 1'b1;
                o_cmd.hide       = (i_stat.op == OP_FREE);
            end
            S_SEARCH:   o_cmd.scan_step = 1'b1;
            S_SHIFT_RD: o_cmd.shift_rd = 1'b1;
            S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            S_PLACE:    o_cmd.place = 1'b1;
            S_EMIT1: begin
                o_cmd.emit1 = 1'b1;
                o_cmd.store = 1'b1;
            end
            S_EMIT2: o_cmd.emit2 = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/lzt_dpath.sv
// ----------------------------------------------------------------------------
// lzt_dpath: slot records, order table and result formatting
// Holds the slot memories, the order table and the top level register.
// ----------------------------------------------------------------------------
module lzt_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lzt_pkg::t_cmd         i_cmd,
    output lzt_pkg::t_stat        o_stat,
    input  logic [2:0]            i_operation,
    input  logic [7:0]            i_slot,
    input  logic signed [9:0]     i_new_height,
    input  logic signed [11:0]    i_pos_x,
    input  logic signed [11:0]    i_pos_y,
    input  logic [10:0]           i_buf_width,
    input  logic [10:0]           i_buf_height,
    input  logic signed [8:0]     i_color_key,
    input  logic [10:0]           i_rel_x0,
    input  logic [10:0]           i_rel_y0,
    input  logic [10:0]           i_rel_x1,
    input  logic [10:0]           i_rel_y1,
    output logic                  o_valid,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_result_slot,
    output logic signed [12:0]    o_rect_x0,
    output logic signed [12:0]    o_rect_y0,
    output logic signed [12:0]    o_rect_x1,
    output logic signed [12:0]    o_rect_y1,
    output logic                  o_last
);
    import lzt_pkg::*;

    // Slot records: used bits in flops, the rest in memories.
    logic [MAX_LAYERS-1:0]   r_used;
    logic signed [LW-1:0]    m_level [MAX_LAYERS];
    logic signed [11:0]      m_ox    [MAX_LAYERS];
    logic signed [11:0]      m_oy    [MAX_LAYERS];
    logic [10:0]             m_w     [MAX_LAYERS];
    logic [10:0]             m_h     [MAX_LAYERS];
    logic signed [8:0]       m_key   [MAX_LAYERS];
    logic [SW-1:0]           m_order [MAX_LAYERS];

    logic signed [LW-1:0] r_top;

    // Captured input word.
    t_op                  r_op;
    logic [7:0]           r_slot;
    logic signed [9:0]    r_nh;
    logic signed [11:0]   r_px, r_py;
    logic [10:0]          r_bw, r_bh;
    logic signed [8:0]    r_ck;
    logic [10:0]          r_rx0, r_ry0, r_rx1, r_ry1;

    // Slot record read out.
    logic signed [LW-1:0] r_old;
    logic signed [11:0]   r_ox, r_oy;
    logic [10:0]          r_w, r_h;
    logic                 r_vs;

    // Level change bookkeeping.
    logic signed [LW-1:0] r_new;    // clamped target level
    logic signed [LW-1:0] r_k;      // shift position
    logic                 r_dir;    // 1: entries move up (shift position decreasing)
    logic signed [LW-1:0] r_kend;
    logic [SW-1:0]        r_moved;  // entry read for the move
    logic [SW-1:0]        r_scan;
    logic                 r_scan_end;
    logic                 r_found;

    logic [SW-1:0] w_s;
    assign w_s = r_slot[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_slot <= i_slot;
            r_nh  <= i_new_height;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_bw  <= i_buf_width;
            r_bh  <= i_buf_height;
            r_ck  <= i_color_key;
            r_rx0 <= i_rel_x0;
            r_ry0 <= i_rel_y0;
            r_rx1 <= i_rel_x1;
            r_ry1 <= i_rel_y1;
        end
    end

    // Record read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_slot) begin
            r_old <= m_level[w_s];
            r_ox  <= m_ox[w_s];
            r_oy  <= m_oy[w_s];
            r_w   <= m_w[w_s];
            r_h   <= m_h[w_s];
            r_vs  <= r_used[w_s] && (r_op <= OP_FREE);
        end
    end

    // Clamp of the requested height.
    logic signed [LW:0] w_req, w_lim, w_cl;
    always_comb begin
        w_req = i_cmd.hide ? -(LW+1)'(1) : (LW+1)'(r_nh);
        w_lim = (r_old >= 0) ? (LW+1)'(r_top) : (LW+1)'(r_top) + (LW+1)'(1);
        w_cl  = w_req;
        if (w_cl > w_lim) w_cl = w_lim;
        if (w_cl < -(LW+1)'(1)) w_cl = -(LW+1)'(1);
    end

    logic w_to_hidden;
    assign w_to_hidden = (r_new < 0);

    // Shift loop state, order table and levels.
    logic signed [LW-1:0] w_src;
    assign w_src = r_dir ? r_k - LW'(1) : r_k + LW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= -LW'(1);
            r_used     <= '0;
            r_scan_end <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.calc_level) begin
                r_new <= LW'(w_cl);
                if (r_old > LW'(w_cl)) begin
                    if (w_cl >= 0) begin
                        r_dir <= 1'b1; r_k <= r_old; r_kend <= LW'(w_cl);
                    end else begin
                        r_dir <= 1'b0; r_k <= r_old; r_kend <= r_top;
                    end
                end else if (r_old < LW'(w_cl)) begin
                    if (r_old >= 0) begin
                        r_dir <= 1'b0; r_k <= r_old; r_kend <= LW'(w_cl);
                    end else begin
                        // Open a gap: move entries top..new up by one.
                        r_dir <= 1'b1; r_k <= r_top + LW'(1); r_kend <= LW'(w_cl);
                    end
                end else begin
                    r_k <= '0; r_kend <= '0; r_dir <= 1'b0;
                end
            end
            if (i_cmd.scan_start) begin
                r_scan     <= '0;
                r_scan_end <= 1'b0;
                r_found    <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (!r_used[r_scan]) begin
                    r_found <= 1'b1;
                end else if (r_scan == SW'(MAX_LAYERS-1)) begin
                    r_scan_end <= 1'b1;
                end else begin
                    r_scan <= r_scan + SW'(1);
                end
            end
            if (i_cmd.shift_rd) r_moved <= m_order[w_src[SW-1:0]];
            if (i_cmd.shift_wr) r_k <= w_src;
            if (i_cmd.place && r_old < 0) r_top <= r_top + LW'(1);
            if (i_cmd.store && o_stat.changed && w_to_hidden && r_vs
                && (r_op == OP_HEIGHT || r_op == OP_FREE))
                r_top <= r_top - LW'(1);
            if (i_cmd.store) begin
                if (r_op == OP_ALLOC && r_found) r_used[r_scan] <= 1'b1;
                if (r_op == OP_FREE && r_vs) r_used[w_s] <= 1'b0;
            end
        end
    end

    logic w_alloc_wr;
    assign w_alloc_wr = i_cmd.store && r_op == OP_ALLOC && r_found;

    // Order table: one write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_wr) m_order[r_k[SW-1:0]] <= r_moved;
        else if (i_cmd.place) m_order[r_new[SW-1:0]] <= w_s;
    end

    // Level memory: renumber moved slot, write own level, or set a new or hidden slot to -1.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_wr) m_level[r_moved] <= r_k;
        else if (i_cmd.place) m_level[w_s] <= r_new;
        else if (w_alloc_wr) m_level[r_scan] <= -LW'(1);
        else if (i_cmd.store && r_vs && o_stat.changed && w_to_hidden
                 && (r_op == OP_HEIGHT || r_op == OP_FREE))
            m_level[w_s] <= -LW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && r_vs && r_op == OP_SETSIZE) begin
            m_w[w_s]   <= r_bw;
            m_h[w_s]   <= r_bh;
            m_key[w_s] <= r_ck;
        end
        if (i_cmd.store && r_vs && r_op == OP_SLIDE) begin
            m_ox[w_s] <= r_px;
            m_oy[w_s] <= r_py;
        end
    end

    // Status.
    always_comb begin
        o_stat.op         = r_op;
        o_stat.valid_slot = r_vs;
        o_stat.shown      = (r_old >= 0);
        o_stat.scan_hit   = !r_used[r_scan];
        o_stat.scan_end   = r_scan_end || (r_scan == SW'(MAX_LAYERS-1));
        o_stat.changed    = (r_new != r_old);
        o_stat.shift_more = o_stat.changed && (r_dir ? (r_k > r_kend) : (r_k < r_kend));
        o_stat.to_hidden  = w_to_hidden;
    end

    // Results.
    logic signed [12:0] w_ox, w_oy, w_nx, w_ny;
    assign w_ox = 13'(r_ox);
    assign w_oy = 13'(r_oy);
    assign w_nx = 13'(r_px);
    assign w_ny = 13'(r_py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit1 || i_cmd.emit2;
        end
        o_result_slot <= r_slot;
        o_last    <= 1'b1;
        o_kind    <= K_DONE;
        o_rect_x0 <= '0;
        o_rect_y0 <= '0;
        o_rect_x1 <= '0;
        o_rect_y1 <= '0;
        if (i_cmd.emit2) begin
            o_kind    <= K_RECT;
            o_rect_x0 <= w_nx;
            o_rect_y0 <= w_ny;
            o_rect_x1 <= w_nx + 13'(r_w);
            o_rect_y1 <= w_ny + 13'(r_h);
        end else if (r_op == OP_ALLOC) begin
            o_kind        <= r_found ? K_ALLOC : K_FULL;
            o_result_slot <= r_found ? 8'(r_scan) : 8'd0;
        end else if (r_vs && r_old >= 0 && r_op == OP_REFRESH) begin
            o_kind    <= K_RECT;
            o_rect_x0 <= w_ox + 13'(r_rx0);
            o_rect_y0 <= w_oy + 13'(r_ry0);
            o_rect_x1 <= w_ox + 13'(r_rx1);
            o_rect_y1 <= w_oy + 13'(r_ry1);
        end else if (r_vs && ((r_op == OP_SLIDE && r_old >= 0)
                 || (r_op == OP_FREE && r_old >= 0)
                 || (r_op == OP_HEIGHT && o_stat.changed))) begin
            o_kind    <= K_RECT;
            o_rect_x0 <= w_ox;
            o_rect_y0 <= w_oy;
            o_rect_x1 <= w_ox + 13'(r_w);
            o_rect_y1 <= w_oy + 13'(r_h);
            o_last    <= !(r_op == OP_SLIDE);
        end
    end

endmodule

FILE: hdl/layer_zorder_table_core.sv
// ----------------------------------------------------------------------------
// layer_zorder_table_core: display layer z-order manager
// Slot pool with z-order table; reports dirty rectangles per operation.
// ----------------------------------------------------------------------------
// Channel   Handshake            Fields
// command   start / busy         i_operation .. i_rel_y1
// result    o_valid strobe       o_kind .. o_last
//
// One operation at a time. A slide of a shown layer gives a second result
// word. Allocation scans one slot per cycle (up to 256). A height change
// or a free moves each order-table entry through a read and a write state,
// ends the move with a final read state, and places a layer that stays
// shown in a place state.
// Reset clears the used bits and the top level; no clearing pass.
// Results are one-cycle strobes; the receiver cannot stall.
module layer_zorder_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic [7:0]         i_slot,
    input  logic signed [9:0]  i_new_height,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic [10:0]        i_buf_width,
    input  logic [10:0]        i_buf_height,
    input  logic signed [8:0]  i_color_key,
    input  logic [10:0]        i_rel_x0,
    input  logic [10:0]        i_rel_y0,
    input  logic [10:0]        i_rel_x1,
    input  logic [10:0]        i_rel_y1,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_result_slot,
    output logic signed [12:0] o_rect_x0,
    output logic signed [12:0] o_rect_y0,
    output logic signed [12:0] o_rect_x1,
    output logic signed [12:0] o_rect_y1,
    output logic               o_last
);
    import lzt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    lzt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lzt_dpath u_dpath (
        .i_clk, .i_rst_n,
        .i_cmd (w_cmd), .o_stat (w_stat),
        .i_operation, .i_slot, .i_new_height, .i_pos_x, .i_pos_y,
        .i_buf_width, .i_buf_height, .i_color_key,
        .i_rel_x0, .i_rel_y0, .i_rel_x1, .i_rel_y1,
        .o_valid, .o_kind, .o_result_slot,
        .o_rect_x0, .o_rect_y0, .o_rect_x1, .o_rect_y1, .o_last
    );

endmodule

FILE: hdl/lzt_checker.sv
// ----------------------------------------------------------------------------
// lzt_checker: port-level checks of the layer z-order table
// Watches the command and result ports of the top level.
// ----------------------------------------------------------------------------
module lzt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_valid,
    input logic [1:0] i_kind,
    input logic       i_last
);
    import lzt_pkg::*;

    // An accepted word always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy) else $error("accept without busy");

    // Only dirty rectangles may be followed by more words.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_kind == K_RECT) else $error("non-last kind");

    // A non-last word is followed right away by the final one.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |=> i_valid && i_last) else $error("pair broken");

    // The final word of an operation frees the block.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> !i_busy) else $error("busy after last");

endmodule

bind layer_zorder_table_core lzt_checker u_lzt_checker (
    .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
    .i_valid(o_valid), .i_kind(o_kind), .i_last(o_last)
);
